### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the timer block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define PT_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, checked at every edge including during reset.
`define PT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/pt2pwm_pkg.sv
// Types and constants of the period timer with two PWM channels.
// Used by the timebase, the channel and the top level; depends on nothing.
`timescale 1ns / 1ps

package pt2pwm_pkg;

    localparam int NUM_CHAN_SLOTS = 2;

    // timer_control bit positions
    localparam int TC_PRE4_BIT   = 0;
    localparam int TC_PRE16_BIT  = 1;
    localparam int TC_ENABLE_BIT = 2;
    localparam int TC_POST_LSB   = 3;
    localparam int TC_POST_MSB   = 6;

    localparam logic [4:0] PRESCALE_1  = 5'd1;
    localparam logic [4:0] PRESCALE_4  = 5'd4;
    localparam logic [4:0] PRESCALE_16 = 5'd16;

    typedef enum logic [2:0] {
        REG_TIMER_CONTROL = 3'd0,
        REG_PERIOD        = 3'd1,
        REG_PWM1_ENABLE   = 3'd2,
        REG_PWM2_ENABLE   = 3'd3,
        REG_DUTY1         = 3'd4,
        REG_DUTY2         = 3'd5,
        REG_PIN1_OUTPUT   = 3'd6,
        REG_PIN2_OUTPUT   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic       run;
        logic       match;
        logic       irq;
        logic [7:0] timer;
    } tb_status_t;

    typedef struct packed {
        logic       active;
        logic       pin_out;
        logic [7:0] duty;
    } chan_cfg_t;

endpackage

### hw/rtl/pt2pwm_timebase.sv
// Prescaler, 8-bit timer with period match, and postscaler.
// Depends on pt2pwm_pkg.
`timescale 1ns / 1ps

module pt2pwm_timebase
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [6:0]             timer_control,
    input  logic [7:0]             period,
    output pt2pwm_pkg::tb_status_t status
);

    logic [4:0] prescale_count_reg;
    logic [4:0] prescale_count_next;
    logic [4:0] postscale_count_reg;
    logic [4:0] postscale_count_next;
    logic [7:0] timer_count_reg;
    logic [7:0] timer_count_next;

    logic [4:0] pre_limit;
    logic [4:0] post_limit;
    logic [4:0] pre_inc;
    logic [4:0] post_inc;
    logic [7:0] timer_inc;
    logic       run;
    logic       match;
    logic       irq;

    always_comb
    begin
        if (timer_control[pt2pwm_pkg::TC_PRE16_BIT])
        begin
            pre_limit = pt2pwm_pkg::PRESCALE_16;
        end
        else if (timer_control[pt2pwm_pkg::TC_PRE4_BIT])
        begin
            pre_limit = pt2pwm_pkg::PRESCALE_4;
        end
        else
        begin
            pre_limit = pt2pwm_pkg::PRESCALE_1;
        end
        post_limit = {1'b0, timer_control[pt2pwm_pkg::TC_POST_MSB:pt2pwm_pkg::TC_POST_LSB]}
                     + 5'd1;

        run       = step & timer_control[pt2pwm_pkg::TC_ENABLE_BIT];
        pre_inc   = prescale_count_reg + 5'd1;
        post_inc  = postscale_count_reg + 5'd1;
        timer_inc = timer_count_reg + 8'd1;

        prescale_count_next  = prescale_count_reg;
        postscale_count_next = postscale_count_reg;
        timer_count_next     = timer_count_reg;
        match                = 1'b0;
        irq                  = 1'b0;

        if (run)
        begin
            if (pre_inc >= pre_limit)
            begin
                prescale_count_next = 5'd0;
                if (timer_inc == period)
                begin
                    timer_count_next = 8'd0;
                    match            = 1'b1;
                    if (post_inc >= post_limit)
                    begin
                        irq                  = 1'b1;
                        postscale_count_next = 5'd0;
                    end
                    else
                    begin
                        postscale_count_next = post_inc;
                    end
                end
                else
                begin
                    timer_count_next = timer_inc;
                end
            end
            else
            begin
                prescale_count_next = pre_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg  <= 5'd0;
            postscale_count_reg <= 5'd0;
            timer_count_reg     <= 8'd0;
        end
        else
        begin
            prescale_count_reg  <= prescale_count_next;
            postscale_count_reg <= postscale_count_next;
            timer_count_reg     <= timer_count_next;
        end
    end

    assign status.run   = run;
    assign status.match = match;
    assign status.irq   = irq;
    assign status.timer = timer_count_next;

endmodule

### hw/rtl/pt2pwm_channel.sv
// One PWM channel: duty latch at period match and output level.
// Depends on pt2pwm_pkg.
`timescale 1ns / 1ps

module pt2pwm_channel
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pt2pwm_pkg::chan_cfg_t  cfg,
    input  pt2pwm_pkg::tb_status_t status,
    output logic                   level
);

    logic [7:0] latched_duty_reg;
    logic [7:0] latched_duty_next;
    logic       level_reg;
    logic       level_next;

    always_comb
    begin
        latched_duty_next = latched_duty_reg;
        level_next        = level_reg;
        if (status.match && cfg.active)
        begin
            latched_duty_next = cfg.duty;
            if (cfg.pin_out)
            begin
                level_next = 1'b1;
            end
        end
        // drop the level once the timer reaches the duty
        if (status.run && cfg.active && cfg.pin_out && (status.timer >= latched_duty_next))
        begin
            level_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_duty_reg <= 8'd0;
            level_reg        <= 1'b0;
        end
        else
        begin
            latched_duty_reg <= latched_duty_next;
            level_reg        <= level_next;
        end
    end

    assign level = level_next;

endmodule

### hw/rtl/period_timer_with_two_pwm_top.sv
// Top level of the period timer with two PWM channels: stream ports,
// configuration registers, input and result registers.
// Depends on pt2pwm_pkg, pt2pwm_timebase and pt2pwm_channel.
//
//  channel   direction  accepted when            contents
//  s_axis    in         tvalid & tready          one tick
//  m_axis    out        tvalid & tready          timer value, interrupt, levels, match
//  cfg       in         cfg_we                   register index and write data
//
// Each tick passes the input register, then the timer and channel update in one pass
// into the result register. One tick per cycle while m_axis is not stalled.
// Reset clears the counters, latched duties, levels and all configuration.
// A stall on m_axis holds the result register; the input register still takes one
// more transaction before s_axis_tready falls.
`timescale 1ns / 1ps

module period_timer_with_two_pwm_top
#(
    parameter int PWM_CHANNELS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] timer_value, [8] interrupt_pulse,
                                        // [9] pwm1_level, [10] pwm2_level,
                                        // [11] period_match, [15:12] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic [6:0] timer_control_reg;
    logic [7:0] period_reg;
    logic [1:0] pwm_en_reg;
    logic [7:0] duty_reg [pt2pwm_pkg::NUM_CHAN_SLOTS];
    logic [1:0] pin_out_reg;

    logic        in_valid_reg;
    logic        tick_reg;
    logic        out_valid_reg;
    logic [11:0] out_data_reg;

    logic                   advance;
    logic                   step;
    pt2pwm_pkg::tb_status_t status;
    logic [1:0]             level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_control_reg <= 7'd0;
            period_reg        <= 8'd0;
            pwm_en_reg        <= 2'b00;
            duty_reg[0]       <= 8'd0;
            duty_reg[1]       <= 8'd0;
            pin_out_reg       <= 2'b00;
        end
        else if (cfg_we)
        begin
            unique case (pt2pwm_pkg::reg_index_t'(cfg_index))
                pt2pwm_pkg::REG_TIMER_CONTROL: timer_control_reg <= cfg_wdata[6:0];
                pt2pwm_pkg::REG_PERIOD:        period_reg        <= cfg_wdata;
                pt2pwm_pkg::REG_PWM1_ENABLE:   pwm_en_reg[0]     <= cfg_wdata[0];
                pt2pwm_pkg::REG_PWM2_ENABLE:   pwm_en_reg[1]     <= cfg_wdata[0];
                pt2pwm_pkg::REG_DUTY1:         duty_reg[0]       <= cfg_wdata;
                pt2pwm_pkg::REG_DUTY2:         duty_reg[1]       <= cfg_wdata;
                pt2pwm_pkg::REG_PIN1_OUTPUT:   pin_out_reg[0]    <= cfg_wdata[0];
                pt2pwm_pkg::REG_PIN2_OUTPUT:   pin_out_reg[1]    <= cfg_wdata[0];
                default:                       period_reg        <= period_reg;
            endcase
        end
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            tick_reg <= s_axis_tdata[0];
        end
    end

    pt2pwm_timebase u_timebase
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step && tick_reg),
        .timer_control (timer_control_reg),
        .period        (period_reg),
        .status        (status)
    );

    for (genvar c = 0; c < pt2pwm_pkg::NUM_CHAN_SLOTS; c++)
    begin : g_chan
        if (c < PWM_CHANNELS)
        begin : g_on
            pt2pwm_pkg::chan_cfg_t chan_cfg;

            assign chan_cfg.active  = pwm_en_reg[c];
            assign chan_cfg.pin_out = pin_out_reg[c];
            assign chan_cfg.duty    = duty_reg[c];

            pt2pwm_channel u_channel
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .cfg    (chan_cfg),
                .status (status),
                .level  (level[c])
            );
        end
        else
        begin : g_off
            // hold the reset level
            assign level[c] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {status.match, level[1], level[0], status.irq, status.timer};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

### hw/rtl/pt2pwm_checker.sv
// Port-level checks of the period timer top level, bound to it below.
// Depends on assert_macros.svh and period_timer_with_two_pwm_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pt2pwm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    `PT_ASSERT_RST(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")
    `PT_ASSERT_RST(a_irq_needs_match, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[11],
        "interrupt without period match")
    `PT_ASSERT_RST(a_match_clears_timer, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[7:0] == 8'd0,
        "period match with nonzero timer")
    `PT_ASSERT_RST(a_idle_ready, clk, rst_n,
        !m_axis_tvalid |-> s_axis_tready,
        "input not ready with empty result register")
    `PT_ASSERT_ALWAYS(a_reset_quiet, clk,
        !rst_n |=> !m_axis_tvalid,
        "result valid after reset edge")

endmodule

bind period_timer_with_two_pwm_top pt2pwm_checker u_pt2pwm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
// Testbench for period_timer_with_two_pwm_top: ticks stream in, results are checked
// field by field against a cycle-free predictor of the timer, postscaler and PWM levels.
// Depends on pt2pwm_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int PWM_CHANNELS = 2;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic [3:0] pad;
        logic       match;
        logic       pwm2;
        logic       pwm1;
        logic       irq;
        logic [7:0] timer;
    } tick_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;
    logic                   cfg_we = 1'b0;
    pt2pwm_pkg::reg_index_t cfg_index = pt2pwm_pkg::REG_TIMER_CONTROL;
    logic [7:0]             cfg_wdata = '0;

    // register copies
    logic [6:0] tcon = '0;
    logic [7:0] period_reg = '0;
    logic       pwm_en [2] = '{1'b0, 1'b0};
    logic       pin_out [2] = '{1'b0, 1'b0};
    logic [7:0] duty_reg [2] = '{8'd0, 8'd0};

    // timer state
    logic [4:0] pre_cnt = '0;
    logic [4:0] post_cnt = '0;
    logic [7:0] tmr = '0;
    logic [7:0] lat_duty [2] = '{8'd0, 8'd0};
    logic       lvl [2] = '{1'b0, 1'b0};

    logic         pending_ticks [$];
    tick_result_t due_results [$];
    tick_result_t due;
    tick_result_t seen;
    int           mismatches = 0;
    int           ticks_sent = 0;
    int           results_seen = 0;
    int           stall_left = 0;
    int           quiet = 0;

    period_timer_with_two_pwm_top #(
        .PWM_CHANNELS(PWM_CHANNELS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic tick_result_t advance_timer(logic tick);
        tick_result_t r;
        logic [4:0]   pre;
        logic [4:0]   post;
        r = '0;
        if (tick && tcon[pt2pwm_pkg::TC_ENABLE_BIT])
        begin
            pre = tcon[pt2pwm_pkg::TC_PRE16_BIT] ? pt2pwm_pkg::PRESCALE_16 :
                  (tcon[pt2pwm_pkg::TC_PRE4_BIT] ? pt2pwm_pkg::PRESCALE_4 :
                                                   pt2pwm_pkg::PRESCALE_1);
            pre_cnt = pre_cnt + 5'd1;
            if (pre_cnt >= pre)
            begin
                tmr = tmr + 8'd1;
                if (tmr == period_reg)
                begin
                    post = {1'b0, tcon[pt2pwm_pkg::TC_POST_MSB:pt2pwm_pkg::TC_POST_LSB]}
                           + 5'd1;
                    tmr = '0;
                    r.match = 1'b1;
                    post_cnt = post_cnt + 5'd1;
                    if (post_cnt >= post)
                    begin
                        r.irq = 1'b1;
                        post_cnt = '0;
                    end
                    for (int c = 0; c < pt2pwm_pkg::NUM_CHAN_SLOTS; c++)
                    begin
                        if (c < PWM_CHANNELS && pwm_en[c])
                        begin
                            lat_duty[c] = duty_reg[c];
                            if (pin_out[c])
                                lvl[c] = 1'b1;
                        end
                    end
                end
                pre_cnt = '0;
            end
            for (int c = 0; c < pt2pwm_pkg::NUM_CHAN_SLOTS; c++)
            begin
                if (c < PWM_CHANNELS && pwm_en[c] && tmr >= lat_duty[c] && pin_out[c])
                    lvl[c] = 1'b0;
            end
        end
        r.timer = tmr;
        r.pwm1  = lvl[0];
        r.pwm2  = lvl[1];
        return r;
    endfunction

    function automatic logic [7:0] pick_duty(logic [7:0] per);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        else if (r < 20)
            return 8'd255;
        return 8'($urandom_range(0, int'(per) + 1));
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // driver: one tick per transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                due_results.push_back(advance_timer(s_axis_tdata[0]));
                ticks_sent <= ticks_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() != 0 &&
                    ((ticks_sent >= 700 && ticks_sent < 1000) ||
                     $urandom_range(0, 99) >= 36))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, pending_ticks.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none got %h", $time, seen);
                end
                else
                begin
                    due = due_results.pop_front();
                    check_field("timer_value", due.timer, seen.timer);
                    check_field("interrupt_pulse", due.irq, seen.irq);
                    check_field("pwm1_level", due.pwm1, seen.pwm1);
                    check_field("pwm2_level", due.pwm2, seen.pwm2);
                    check_field("period_match", due.match, seen.match);
                    check_field("padding", due.pad, seen.pad);
                end
                results_seen <= results_seen + 1;
            end
            if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready &&
                     (results_seen == 300 || results_seen == 1300))
            begin
                // hold off long enough to back up the input side
                stall_left    <= 120;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= (results_seen >= 700 && results_seen < 1000) ||
                                 $urandom_range(0, 99) >= 36;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(pt2pwm_pkg::reg_index_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pt2pwm_pkg::REG_TIMER_CONTROL: tcon        = val[6:0];
            pt2pwm_pkg::REG_PERIOD:        period_reg  = val;
            pt2pwm_pkg::REG_PWM1_ENABLE:   pwm_en[0]   = val[0];
            pt2pwm_pkg::REG_PWM2_ENABLE:   pwm_en[1]   = val[0];
            pt2pwm_pkg::REG_DUTY1:         duty_reg[0] = val;
            pt2pwm_pkg::REG_DUTY2:         duty_reg[1] = val;
            pt2pwm_pkg::REG_PIN1_OUTPUT:   pin_out[0]  = val[0];
            pt2pwm_pkg::REG_PIN2_OUTPUT:   pin_out[1]  = val[0];
            default:                       ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // unused upper bits carry junk so the register masking gets exercised
    task automatic configure(logic [6:0] tc, logic [7:0] per, logic e1, logic e2,
                             logic [7:0] d1, logic [7:0] d2, logic o1, logic o2);
        write_reg(pt2pwm_pkg::REG_TIMER_CONTROL, {1'($urandom_range(0, 1)), tc});
        write_reg(pt2pwm_pkg::REG_PERIOD, per);
        write_reg(pt2pwm_pkg::REG_PWM1_ENABLE, {7'($urandom_range(0, 127)), e1});
        write_reg(pt2pwm_pkg::REG_PWM2_ENABLE, {7'($urandom_range(0, 127)), e2});
        write_reg(pt2pwm_pkg::REG_DUTY1, d1);
        write_reg(pt2pwm_pkg::REG_DUTY2, d2);
        write_reg(pt2pwm_pkg::REG_PIN1_OUTPUT, {7'($urandom_range(0, 127)), o1});
        write_reg(pt2pwm_pkg::REG_PIN2_OUTPUT, {7'($urandom_range(0, 127)), o2});
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic play_pattern(logic [15:0] bits, int n);
        @(negedge clk);
        for (int i = 0; i < n; i++)
            pending_ticks.push_back(bits[i]);
        drain();
    endtask

    task automatic play_random(int n, int one_pct);
        @(negedge clk);
        repeat (n) pending_ticks.push_back($urandom_range(0, 99) < one_pct);
        drain();
    endtask

    initial
    begin
        logic [6:0] tc;
        logic [7:0] per;
        int         r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // prescale 1, period 3, duty zero on a channel whose pin is an input
        configure(7'h04, 8'd3, 1'b1, 1'b1, 8'd2, 8'd0, 1'b1, 1'b0);
        play_pattern(16'b1101_1111_0111, 12);
        // disabled with both prescale bits and the largest postscale
        configure(7'h7B, 8'd3, 1'b1, 1'b1, 8'd2, 8'd0, 1'b1, 1'b0);
        play_pattern(16'b011, 3);
        // prescale 4, postscale 2, period 1, channels off
        configure(7'h0D, 8'd1, 1'b0, 1'b0, 8'd1, 8'd1, 1'b1, 1'b1);
        play_pattern(16'hFF, 8);

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: configure(7'h04, 8'd0, 1'b1, 1'b1, 8'd0, 8'd255, 1'b1, 1'b1);
                1: configure(7'h7C, 8'd255, 1'b1, 1'b1, 8'd255, 8'd128, 1'b1, 1'b0);
                2: configure(7'h7F, 8'd1, 1'b1, 1'b0, 8'd1, 8'd0, 1'b1, 1'b1);
                3: configure(7'h16, 8'd2, 1'b0, 1'b1, 8'd1, 8'd2, 1'b0, 1'b1);
                default:
                begin
                    r  = $urandom_range(0, 99);
                    tc = {4'($urandom_range(0, 15)), 1'($urandom_range(0, 9) != 0),
                          (r < 60) ? 2'b00 : (r < 80) ? 2'b01 : (r < 90) ? 2'b10 : 2'b11};
                    per = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                                        8'($urandom_range(1, 10));
                    configure(tc, per, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                              pick_duty(per), pick_duty(per),
                              $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
                end
            endcase
            play_random((p < 2) ? 300 : 130, 88);
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
